/* src/qphm_pkg.sv */
package qphm_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int HASH_CYCLES = 2;
  localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

  localparam logic ACT_SEARCH = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic hash;
    logic step;
  } addr_cmd_t;

endpackage

/* src/qphm_ram.sv */
module qphm_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/qphm_addr_unit.sv */
module qphm_addr_unit #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                          clk_i,
  input  qphm_pkg::addr_cmd_t           cmd_i,
  input  logic [qphm_pkg::KEY_W-1:0]    key_i,
  output logic [$clog2(TABLE_SIZE)-1:0] pos_o
);

  import qphm_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int PROD_W = 2 * KEY_W + 1;
  localparam logic [AW:0] N_C = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] N_LOW = AW'(TABLE_SIZE);
  localparam logic [KEY_W:0] RECIP = (KEY_W+1)'(((64'd1 << (KEY_W + AW)) +
                                                 64'(TABLE_SIZE) - 64'd1) /
                                                64'(TABLE_SIZE));
  localparam logic [AW:0] TWO_C = (AW+1)'(2);
  localparam logic [AW-1:0] ODD_INIT = AW'(3 % TABLE_SIZE);
  localparam logic [AW-1:0] SQ_INIT = AW'(1);

  logic [KEY_W-1:0]  key_q, key_d;
  logic [AW-1:0]     quot_q, quot_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     sq_q, sq_d;
  logic [AW-1:0]     odd_q, odd_d;
  logic [PROD_W-1:0] prod;
  logic [2*AW-1:0]   quot_mul;
  logic [AW:0]       pos_sum, sq_sum, odd_sum;

  // Hashing first takes the quotient of the key by TABLE_SIZE from a
  // multiply by its reciprocal, then turns it into the remainder.
  always_comb begin
    prod     = {{(KEY_W+1){1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP};
    quot_mul = {{AW{1'b0}}, quot_q} * {{AW{1'b0}}, N_LOW};
  end

  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, sq_q};
    if (pos_sum >= N_C) begin
      pos_sum = pos_sum - N_C;
    end
    sq_sum = {1'b0, sq_q} + {1'b0, odd_q};
    if (sq_sum >= N_C) begin
      sq_sum = sq_sum - N_C;
    end
    odd_sum = {1'b0, odd_q} + TWO_C;
    if (odd_sum >= N_C) begin
      odd_sum = odd_sum - N_C;
    end
  end

  always_comb begin
    key_d  = key_q;
    quot_d = quot_q;
    pos_d  = pos_q;
    sq_d   = sq_q;
    odd_d  = odd_q;
    if (cmd_i.load) begin
      key_d = key_i;
      pos_d = '0;
      sq_d  = SQ_INIT;
      odd_d = ODD_INIT;
    end else if (cmd_i.hash) begin
      quot_d = prod[KEY_W+AW +: AW];
      pos_d  = key_q[AW-1:0] - quot_mul[AW-1:0];
    end else if (cmd_i.step) begin
      pos_d = pos_sum[AW-1:0];
      sq_d  = sq_sum[AW-1:0];
      odd_d = odd_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    quot_q <= quot_d;
    pos_q  <= pos_d;
    sq_q   <= sq_d;
    odd_q  <= odd_d;
  end

  assign pos_o = pos_q;

endmodule

/* src/quadratic_probe_hash_map.sv */
// Address-to-interface map in an open-addressed table probed by sums of squares.
// The input channel carries one beat per request: action_i selects search or
// insert, address_i is the key and port_value_i the interface stored on insert.
// The output channel returns one beat per request with found_o, port_out_o and
// status_o (ok, not found, or table full on insert).
// After reset the block sweeps the table memory once, one slot per cycle, and
// in_stall_o stays high until the sweep ends, so no beat is taken before then.
// A request then reduces the key to its home slot in S_HASH (a multiply
// by the reciprocal of TABLE_SIZE, then a multiply and subtract), and each
// probe passes through S_READ and S_CHECK, since it is one read of the table
// memory's single read port, which is registered. The result beat is offered
// from the output register once probing ends, with between 1 and TABLE_SIZE
// probes; a lightly loaded table needs only a few.
// One request is processed at a time; in_stall_o is low only while idle, so the
// next beat can be taken at the earliest in the cycle the result is offered.
// The result sits in an output register, so a new beat is accepted while the
// previous result still waits. If out_stall_i holds the output register full
// when the next result is ready, the block waits and commits nothing until
// the register frees up.
module quadratic_probe_hash_map #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [qphm_pkg::KEY_W-1:0]    address_i,
  input  logic [qphm_pkg::VAL_W-1:0]    port_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [qphm_pkg::VAL_W-1:0]    port_out_o,
  output logic [qphm_pkg::STATUS_W-1:0] status_o
);

  import qphm_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int ENTRY_W = 1 + KEY_W + VAL_W;
  localparam logic [AW:0] LAST_TRY = (AW+1)'(TABLE_SIZE - 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
  localparam logic [HASH_CNT_W-1:0] LAST_HASH = HASH_CNT_W'(HASH_CYCLES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           clr_addr_q;
  logic [HASH_CNT_W-1:0]   hash_cnt_q;
  logic [AW:0]             tries_q;
  logic                    action_q;
  logic [KEY_W-1:0]        key_q;
  logic [VAL_W-1:0]        value_q;
  logic                    out_valid_q;
  logic                    found_q;
  logic [VAL_W-1:0]        port_q;
  logic [STATUS_W-1:0]     status_q;

  addr_cmd_t               cmd;
  logic [AW-1:0]           pos;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic                    slot_valid;
  logic [KEY_W-1:0]        slot_key;
  logic [VAL_W-1:0]        slot_value;
  logic                    key_hit;
  logic                    probe_stop;
  logic                    probe_done;
  logic                    commit;
  logic                    out_free;
  logic                    in_take;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign {slot_valid, slot_key, slot_value} = ram_rdata;
  assign key_hit    = slot_valid && (slot_key == key_q);
  assign probe_stop = !slot_valid || key_hit;
  assign probe_done = probe_stop || (tries_q == LAST_TRY);
  assign commit     = (state_q == S_CHECK) && probe_done && out_free;

  always_comb begin
    cmd.load = in_take;
    cmd.hash = (state_q == S_HASH);
    cmd.step = (state_q == S_CHECK) && !probe_stop && (tries_q != LAST_TRY);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = {1'b1, key_q, value_q};
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (commit && probe_stop && action_q == ACT_INSERT) begin
      ram_we = 1'b1;
    end
  end

  qphm_addr_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_addr (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .key_i (address_i),
    .pos_o (pos)
  );

  qphm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      hash_cnt_q  <= '0;
      tries_q     <= '0;
      action_q    <= ACT_SEARCH;
      key_q       <= '0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      port_q      <= '0;
      status_q    <= STATUS_OK;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == LAST_SLOT) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            action_q   <= action_i;
            key_q      <= address_i;
            value_q    <= port_value_i;
            hash_cnt_q <= '0;
            tries_q    <= '0;
            state_q    <= S_HASH;
          end
        end
        S_HASH: begin
          hash_cnt_q <= hash_cnt_q + 1'b1;
          if (hash_cnt_q == LAST_HASH) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (probe_done) begin
            if (out_free) begin
              state_q <= S_IDLE;
              if (action_q == ACT_INSERT) begin
                found_q  <= probe_stop;
                port_q   <= probe_stop ? value_q : '0;
                status_q <= probe_stop ? STATUS_OK : STATUS_FULL;
              end else begin
                found_q  <= key_hit;
                port_q   <= key_hit ? slot_value : '0;
                status_q <= key_hit ? STATUS_OK : STATUS_NOT_FOUND;
              end
            end
          end else begin
            tries_q <= tries_q + 1'b1;
            state_q <= S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign port_out_o  = port_q;
  assign status_o    = status_q;

  a_found_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o == (status_o == STATUS_OK)))
    else $error("found flag disagrees with status");

  a_miss_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (port_out_o == '0))
    else $error("port is nonzero on a miss");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_NOT_FOUND ||
                     status_o == STATUS_FULL))
    else $error("illegal status code");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> tries_q <= LAST_TRY)
    else $error("probe count exceeds table size");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o && ram_we)
    else $error("input taken or no write during clearing sweep");

endmodule
